### src/fsd_pkg.sv
// ----------------------------------------------------------------------------
// fsd_pkg
// Shared types, register codes and arithmetic helpers for the
// Floyd-Steinberg error-diffusion dither.
// ----------------------------------------------------------------------------
package fsd_pkg;

  // Pixel and error widths.
  localparam int GRAY_W = 8;
  localparam int ERR_W  = 10;
  localparam int VAL_W  = 12;   // corrected pixel value, signed
  localparam int SUM_W  = 16;   // 16*v + c*e, signed

  // Configuration port.
  localparam int CFG_ADDR_W     = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int IMAGE_WIDTH_W  = 13;
  localparam int IMAGE_HEIGHT_W = 16;
  localparam int WIDTH_RESET    = 640;
  localparam int HEIGHT_RESET   = 480;

  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // Depth of the queue between the front and back ends.
  localparam int QUEUE_DEPTH = 2;

  // Position flags that the front end attaches to every pixel.
  typedef struct packed {
    logic first_row;
    logic first_col;
    logic last_col;
    logic frame_end;
  } fsd_flags_t;

  localparam int FLAGS_W = $bits(fsd_flags_t);

  // Add weight/16 of an error to a value, truncating toward zero.
  function automatic logic signed [VAL_W-1:0] add_share(
    input logic signed [VAL_W-1:0] v,
    input logic        [2:0]       weight,
    input logic signed [ERR_W-1:0] err
  );
    logic signed [SUM_W-1:0] prod;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] quo;
    prod = SUM_W'($signed({1'b0, weight})) * SUM_W'(err);
    sum  = (SUM_W'(v) <<< 4) + prod;
    quo  = sum >>> 4;
    // An arithmetic shift floors; a negative sum with a remainder rounds up.
    if (sum[SUM_W-1] && (sum[3:0] != 4'd0)) begin
      quo = quo + SUM_W'(1);
    end
    return VAL_W'(quo);
  endfunction

endpackage

### src/floyd_steinberg_dither.sv
// ----------------------------------------------------------------------------
// floyd_steinberg_dither
// Floyd-Steinberg error-diffusion dither: 8-bit grayscale pixels in raster
// order in, one 1-bit pixel out per pixel, with row and frame end marks.
//
//   Channel  Direction  Payload
//   in_      slave      tdata[7:0] = gray_in
//   out_     master     tdata[0] = bit_out, tlast = row_end, tuser[0] = frame_end
//   cfg_     slave      addr 0 = image_width, addr 1 = image_height
//
// One pixel per clock sustained while the output is not stalled; a result
// passes through the queue, the compute stage and the output register.
// The rate is set by the left-neighbor error loop in the back end's compute stage.
// Reset is synchronous, active low; it sets 640 x 480 and restarts at row 0.
// A stalled output holds its register while the queue keeps taking pixels until it is full.
// ----------------------------------------------------------------------------
module floyd_steinberg_dither
  import fsd_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Pixel input.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] gray_in
  // Dithered output.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // [0] bit_out, [7:1] zero
  output logic                  out_tlast,
  output logic [0:0]            out_tuser,  // [0] frame_end
  // Configuration writes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int QW = XW + GRAY_W + FLAGS_W;

  logic             push_valid;
  logic             push_ready;
  logic [XW-1:0]    push_x;
  logic [GRAY_W-1:0] push_gray;
  fsd_flags_t       push_flags;
  logic             pop_valid;
  logic             pop_ready;
  logic [QW-1:0]    pop_data;
  logic             res_bit;

  // Front end: counters and position flags.
  fsd_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .pix_valid  (in_tvalid),
    .pix_ready  (in_tready),
    .pix_gray   (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_x     (push_x),
    .push_gray  (push_gray),
    .push_flags (push_flags)
  );

  // Queue between front and back.
  fsd_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  ({push_x, push_gray, push_flags}),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_data  (pop_data)
  );

  // Back end: error diffusion and line buffer.
  fsd_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_x         (pop_data[QW-1 -: XW]),
    .pop_gray      (pop_data[FLAGS_W +: GRAY_W]),
    .pop_flags     (fsd_flags_t'(pop_data[FLAGS_W-1:0])),
    .res_valid     (out_tvalid),
    .res_ready     (out_tready),
    .res_bit       (res_bit),
    .res_row_end   (out_tlast),
    .res_frame_end (out_tuser[0])
  );

  assign out_tdata = {7'b0, res_bit};

endmodule

### src/fsd_ram.sv
// ----------------------------------------------------------------------------
// fsd_ram
// Generic RAM: one write port, two read ports with registered read data.
// A read in the same cycle as a write to that address returns the old data.
// ----------------------------------------------------------------------------
module fsd_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
  input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
  output logic [WIDTH-1:0]         rd_a_data,
  output logic [WIDTH-1:0]         rd_b_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_a_r;
  logic [WIDTH-1:0] rd_b_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read ports.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= mem_r[rd_a_addr];
      rd_b_r <= mem_r[rd_b_addr];
    end
  end

  assign rd_a_data = rd_a_r;
  assign rd_b_data = rd_b_r;

endmodule

### src/fsd_front.sv
// ----------------------------------------------------------------------------
// fsd_front
// Front end: holds the frame size registers, counts columns and rows, and
// tags each incoming pixel with its position flags.
// ----------------------------------------------------------------------------
module fsd_front
  import fsd_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration writes.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [CFG_ADDR_W-1:0]             cfg_addr,
  input  logic [CFG_DATA_W-1:0]             cfg_data,
  // Pixel input.
  input  logic                              pix_valid,
  output logic                              pix_ready,
  input  logic [GRAY_W-1:0]                 pix_gray,
  // Tagged pixel toward the queue.
  output logic                              push_valid,
  input  logic                              push_ready,
  output logic [$clog2(MAX_WIDTH)-1:0]      push_x,
  output logic [GRAY_W-1:0]                 push_gray,
  output fsd_flags_t                        push_flags
);

  localparam int XW        = $clog2(MAX_WIDTH);
  localparam int ResetW    = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
  localparam int ColLastRst = ResetW - 1;
  localparam int RowLastRst = HEIGHT_RESET - 1;

  logic [XW-1:0]             col_last_r, col_last_nxt;
  logic [IMAGE_HEIGHT_W-1:0] row_last_r, row_last_nxt;
  logic [XW-1:0]             x_r, x_nxt;
  logic [IMAGE_HEIGHT_W-1:0] y_r, y_nxt;
  logic [IMAGE_WIDTH_W-1:0]  wr_width;
  logic [IMAGE_HEIGHT_W-1:0] wr_height;
  logic                      cfg_fire;
  logic                      accept;
  logic                      last_col;
  logic                      last_row;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign wr_width  = cfg_data[IMAGE_WIDTH_W-1:0];
  assign wr_height = cfg_data[IMAGE_HEIGHT_W-1:0];

  // Register decode: keep the last column and last row indexes directly.
  // A zero size acts as one, and the width saturates at the buffer depth.
  always_comb begin
    col_last_nxt = col_last_r;
    row_last_nxt = row_last_r;
    if (cfg_fire) begin
      unique case (cfg_addr)
        REG_IMAGE_WIDTH: begin
          if (wr_width == '0) begin
            col_last_nxt = '0;
          end else if (32'(wr_width) >= MAX_WIDTH) begin
            col_last_nxt = XW'(MAX_WIDTH - 1);
          end else begin
            col_last_nxt = XW'(wr_width - IMAGE_WIDTH_W'(1));
          end
        end
        REG_IMAGE_HEIGHT: begin
          if (wr_height == '0) begin
            row_last_nxt = '0;
          end else begin
            row_last_nxt = wr_height - IMAGE_HEIGHT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Position classification of the pixel on the input.
  assign last_col = (x_r >= col_last_r);
  assign last_row = (y_r >= row_last_r);

  assign push_valid           = pix_valid;
  assign pix_ready            = push_ready;
  assign push_x               = x_r;
  assign push_gray            = pix_gray;
  assign push_flags.first_row = (y_r == '0);
  assign push_flags.first_col = (x_r == '0);
  assign push_flags.last_col  = last_col;
  assign push_flags.frame_end = last_col && last_row;

  assign accept = pix_valid && push_ready;

  // Raster counters.
  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    if (accept) begin
      if (last_col) begin
        x_nxt = '0;
        y_nxt = last_row ? '0 : (y_r + IMAGE_HEIGHT_W'(1));
      end else begin
        x_nxt = x_r + XW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_last_r <= XW'(ColLastRst);
      row_last_r <= IMAGE_HEIGHT_W'(RowLastRst);
      x_r        <= '0;
      y_r        <= '0;
    end else begin
      col_last_r <= col_last_nxt;
      row_last_r <= row_last_nxt;
      x_r        <= x_nxt;
      y_r        <= y_nxt;
    end
  end

endmodule

### src/fsd_queue.sv
// ----------------------------------------------------------------------------
// fsd_queue
// Small register queue that decouples the front end from the back end.
// Ready toward the writer depends only on the fill count.
// ----------------------------------------------------------------------------
module fsd_queue #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             push;
  logic             pop;

  assign wr_ready = (count_r != CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = slot_r[rptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Pointer and count update, with wrap at the depth.
  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (32'(wptr_r) == DEPTH - 1) ? '0 : (wptr_r + PW'(1));
    end
    if (pop) begin
      rptr_nxt = (32'(rptr_r) == DEPTH - 1) ? '0 : (rptr_r + PW'(1));
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= wr_data;
    end
  end

endmodule

### src/fsd_back.sv
// ----------------------------------------------------------------------------
// fsd_back
// Back end: reads the previous row's errors from the line buffer, applies
// the four weighted corrections, thresholds the pixel and writes its error
// back. Results leave through an output register.
// ----------------------------------------------------------------------------
module fsd_back
  import fsd_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Tagged pixel from the queue.
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  logic [$clog2(MAX_WIDTH)-1:0] pop_x,
  input  logic [GRAY_W-1:0]            pop_gray,
  input  fsd_flags_t                   pop_flags,
  // Result.
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic                         res_bit,
  output logic                         res_row_end,
  output logic                         res_frame_end
);

  localparam int XW = $clog2(MAX_WIDTH);

  // Compute stage.
  logic                     s1_valid_r, s1_valid_nxt;
  logic [XW-1:0]            s1_x_r;
  logic [GRAY_W-1:0]        s1_gray_r;
  fsd_flags_t               s1_flags_r;
  // Write bypass for a read issued in the cycle of the write.
  logic                     byp_valid_r;
  logic [XW-1:0]            byp_addr_r;
  logic signed [ERR_W-1:0]  byp_data_r;
  // Neighbor errors: left from the current row, up-left from the previous row.
  logic signed [ERR_W-1:0]  left_r;
  logic signed [ERR_W-1:0]  diag_r;
  // Output register.
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_bit_r;
  logic                     out_row_end_r;
  logic                     out_frame_end_r;

  logic                     fire;
  logic                     load;
  logic [ERR_W-1:0]         rd_up;
  logic [ERR_W-1:0]         rd_upr;
  logic signed [ERR_W-1:0]  up_err;
  logic signed [ERR_W-1:0]  upr_err;
  logic signed [VAL_W-1:0]  v_diag;
  logic signed [VAL_W-1:0]  v_up;
  logic signed [VAL_W-1:0]  v_upr;
  logic signed [VAL_W-1:0]  v_final;
  logic                     pix_bit;
  logic signed [VAL_W-1:0]  err_full;
  logic signed [ERR_W-1:0]  err;

  // Pipeline handshake.
  assign fire      = s1_valid_r && (!out_valid_r || res_ready);
  assign pop_ready = !s1_valid_r || fire;
  assign load      = pop_valid && pop_ready;

  // Line buffer of the previous row's errors: up and up-right reads.
  fsd_ram #(
    .WIDTH (ERR_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk       (clk),
    .wr_en     (fire),
    .wr_addr   (s1_x_r),
    .wr_data   (err),
    .rd_en     (load),
    .rd_a_addr (pop_x),
    .rd_b_addr (pop_x + XW'(1)),
    .rd_a_data (rd_up),
    .rd_b_data (rd_upr)
  );

  // Take the error just written when a one- or two-column row reads it back.
  always_comb begin
    up_err  = $signed(rd_up);
    upr_err = $signed(rd_upr);
    if (byp_valid_r && (byp_addr_r == s1_x_r)) begin
      up_err = byp_data_r;
    end
    if (byp_valid_r && (byp_addr_r == (s1_x_r + XW'(1)))) begin
      upr_err = byp_data_r;
    end
  end

  // Corrections in order: up-left, up, up-right, then left.
  always_comb begin
    v_diag = VAL_W'(s1_gray_r);
    if (!s1_flags_r.first_row && !s1_flags_r.first_col) begin
      v_diag = add_share(VAL_W'(s1_gray_r), 3'd1, diag_r);
    end
    v_up = v_diag;
    if (!s1_flags_r.first_row) begin
      v_up = add_share(v_diag, 3'd5, up_err);
    end
    v_upr = v_up;
    if (!s1_flags_r.first_row && !s1_flags_r.last_col) begin
      v_upr = add_share(v_up, 3'd3, upr_err);
    end
    v_final = v_upr;
    if (!s1_flags_r.first_col) begin
      v_final = add_share(v_upr, 3'd7, left_r);
    end
  end

  // Threshold and quantization error.
  assign pix_bit  = (v_final > 12'sd128);
  assign err_full = pix_bit ? (v_final - 12'sd255) : v_final;
  assign err      = ERR_W'(err_full);

  // Valid flags.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (res_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      byp_valid_r <= 1'b0;
      left_r      <= '0;
      diag_r      <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (load) begin
        byp_valid_r <= fire;
      end
      if (fire) begin
        left_r <= err;
        diag_r <= up_err;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (load) begin
      s1_x_r     <= pop_x;
      s1_gray_r  <= pop_gray;
      s1_flags_r <= pop_flags;
      byp_addr_r <= s1_x_r;
      byp_data_r <= err;
    end
    if (fire) begin
      out_bit_r       <= pix_bit;
      out_row_end_r   <= s1_flags_r.last_col;
      out_frame_end_r <= s1_flags_r.frame_end;
    end
  end

  assign res_valid     = out_valid_r;
  assign res_bit       = out_bit_r;
  assign res_row_end   = out_row_end_r;
  assign res_frame_end = out_frame_end_r;

endmodule

### src/fsd_checker.sv
// ----------------------------------------------------------------------------
// fsd_checker
// Port-level checks on the dither's output stream, bound to the top level.
// ----------------------------------------------------------------------------
module fsd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic [0:0] out_tuser
);

  // Nothing leaves in the cycle after a reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output valid dropped while stalled");

  // A stalled result keeps its payload.
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))
    else $error("output payload changed while stalled");

  // A frame always ends on the last pixel of a row.
  a_frame_on_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("frame end without row end");

  // Only the dithered bit is carried in the data byte.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:1] == 7'b0))
    else $error("output padding bits not zero");

endmodule

bind floyd_steinberg_dither fsd_checker u_fsd_checker (.*);
